### rtl/core/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // Ring geometry
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value_in;
    } deq_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic [STATUS_W-1:0]     status;
        logic                    last;
        logic [OCC_W-1:0]        occupancy;
    } deq_out_t;

    // Result beat handed from the sequencer to the output stage
    typedef struct packed {
        logic     valid;
        deq_out_t beat;
    } deq_res_t;

endpackage

`default_nettype wire

### rtl/core/double_ended_queue.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit values held in a ring of DEPTH
// words in one synchronous RAM, with front index and entry count in flops.
// Each request beat pushes at the front or back, pops from the front or back,
// or lists the contents front to back; every request yields one response
// beat, except a list of N held entries, which yields N beats with last set
// on the back entry, and an unknown op, which yields none. A push is answered
// from the idle state, a pop from the RAM's registered read, and a list
// streams one beat per cycle while the response register takes beats. A new
// request enters only when the response register is empty or its beat is
// taken in the same cycle, so a stalled response holds off requests; the RAM
// needs no clearing after reset.
module double_ended_queue
    import deq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire deq_in_t  req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output deq_out_t      rsp
);

    deq_res_t res;
    logic     res_ready;
    logic     rsp_valid_reg, rsp_valid_next;
    deq_out_t rsp_reg;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res       (res),
        .res_ready (res_ready)
    );

    // Accept a new beat when the register is empty or draining
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_ready)
        begin
            rsp_valid_next = res.valid;
        end
    end

    // Hold the response beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            rsp_reg <= res.beat;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

### rtl/core/deq_ram.sv
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/deq_ctrl.sv
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    input  wire deq_in_t req,
    output deq_res_t     res,
    input  wire logic    res_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] idx_reg, idx_next;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    logic             accept;
    logic             full;
    logic             empty;
    logic [PTR_W-1:0] front_dec;
    logic [PTR_W-1:0] front_inc;
    logic [PTR_W-1:0] back_pos;
    logic [PTR_W-1:0] tail_pos;
    logic [PTR_W-1:0] idx_inc;
    logic             list_last;

    // Ring position: base plus offset, wrapped modulo DEPTH
    function automatic logic [PTR_W-1:0] ring_add(
        input logic [PTR_W-1:0] base,
        input logic [PTR_W-1:0] offset
    );
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (PTR_W+1)'(DEPTH))
        begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    deq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.value_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Derived pointers
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - PTR_W'(1);
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + PTR_W'(1);
    assign back_pos  = ring_add(front_reg, count_reg[PTR_W-1:0]);
    assign tail_pos  = ring_add(front_reg, count_reg[PTR_W-1:0] - PTR_W'(1));
    assign idx_inc   = idx_reg + PTR_W'(1);
    assign list_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign req_ready = (state_reg == S_IDLE) && res_ready;
    assign accept    = req_valid && req_ready;

    // Sequence pushes, pops and the list walk around the single read port
    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ram_we     = 1'b0;
        ram_waddr  = front_reg;
        ram_re     = 1'b0;
        ram_raddr  = front_reg;
        res        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            res.valid     = 1'b1;
                            res.beat.last = 1'b1;
                            if (full)
                            begin
                                res.beat.status    = STAT_FULL;
                                res.beat.occupancy = OCC_W'(count_reg);
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (req.op == OP_PUSH_FRONT)
                                begin
                                    ram_waddr  = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    ram_waddr = back_pos;
                                end
                                count_next         = count_reg + CNT_W'(1);
                                res.beat.status    = STAT_OK;
                                res.beat.occupancy = OCC_W'(count_reg + CNT_W'(1));
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_LIST:
                        begin
                            if (empty)
                            begin
                                res.valid          = 1'b1;
                                res.beat.last      = 1'b1;
                                res.beat.status    = STAT_EMPTY;
                                res.beat.occupancy = OCC_W'(count_reg);
                            end
                            else
                            begin
                                ram_re = 1'b1;
                                if (req.op == OP_POP_FRONT)
                                begin
                                    ram_raddr  = front_reg;
                                    front_next = front_inc;
                                    count_next = count_reg - CNT_W'(1);
                                    state_next = S_POP;
                                end
                                else if (req.op == OP_POP_BACK)
                                begin
                                    ram_raddr  = tail_pos;
                                    count_next = count_reg - CNT_W'(1);
                                    state_next = S_POP;
                                end
                                else
                                begin
                                    ram_raddr  = front_reg;
                                    idx_next   = '0;
                                    state_next = S_LIST;
                                end
                            end
                        end
                        default:
                        begin
                            // Unknown op: drop the beat
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (res_ready)
                begin
                    res.valid          = 1'b1;
                    res.beat.value_out = ram_rdata;
                    res.beat.status    = STAT_OK;
                    res.beat.last      = 1'b1;
                    res.beat.occupancy = OCC_W'(count_reg);
                    state_next         = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (res_ready)
                begin
                    res.valid          = 1'b1;
                    res.beat.value_out = ram_rdata;
                    res.beat.status    = STAT_OK;
                    res.beat.last      = list_last;
                    res.beat.occupancy = OCC_W'(count_reg);
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ring_add(front_reg, idx_inc);
                        idx_next  = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Occupancy never exceeds the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("deq_ctrl: entry count above depth");

    // The list walk stays inside the held entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("deq_ctrl: list index past held entries");

    // Only the list walk produces a beat that is not the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.beat.last) |-> (state_reg == S_LIST))
        else $error("deq_ctrl: non-final beat outside list walk");

    // A pop on an empty queue leaves the state alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty && (req.op == OP_POP_FRONT || req.op == OP_POP_BACK))
        |=> (count_reg == $past(count_reg) && front_reg == $past(front_reg)))
        else $error("deq_ctrl: empty pop changed the queue");

    // A memory read only starts when a result slot will follow
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (state_reg == S_POP || state_reg == S_LIST))
        else $error("deq_ctrl: read issued with no pending result");

endmodule

`default_nettype wire
